// File: hw/rtl/thlk_pkg.sv
package thlk_pkg;

  // Number of key codes that the map and the held bits cover.
  localparam int KEY_CODES = 256;
  localparam int KEY_W     = 8;
  localparam int KEY_IDX_W = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;

  localparam logic [KEY_W-1:0] ACT_KEY_RESET = 8'd32;
  localparam logic [7:0]       FLAG_KEYUP    = 8'h02;
  localparam logic [1:0]       LEVEL_MAX     = 2'd2;
  localparam logic [1:0]       LEVEL_TAP     = 2'd1;

  typedef enum logic [1:0] {
    FUNC_DOWN  = 2'd0,
    FUNC_UP    = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ACT_PASS    = 2'd0,
    ACT_SWALLOW = 2'd1,
    ACT_EMIT    = 2'd2
  } act_t;

  typedef struct packed {
    func_t            func;
    logic [KEY_W-1:0] key;
    logic             injected;
    logic [7:0]       target;
    logic [7:0]       flags;
  } item_t;

  typedef struct packed {
    logic [7:0] flags;
    logic [7:0] target;
  } entry_t;

  typedef struct packed {
    act_t       action;
    logic [7:0] key;
    logic [7:0] flags;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } decision_t;

endpackage

// File: hw/rtl/thlk_map_mem.sv
module thlk_map_mem import thlk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [KEY_IDX_W-1:0] waddr,
  input  entry_t               wdata,
  input  logic                 re,
  input  logic [KEY_IDX_W-1:0] raddr,
  output entry_t               rdata
);

  entry_t               mem [KEY_CODES];
  logic [KEY_CODES-1:0] valid;
  entry_t               rd;
  logic                 rd_valid;

  // Entries never written since reset read as zero, i.e. unmapped.
  always_ff @(posedge clk) begin
    if (re) begin
      rd <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (re) begin
        rd_valid <= valid[raddr];
      end
      if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_valid ? rd : '0;

endmodule

// File: hw/rtl/thlk_layer_ctl.sv
module thlk_layer_ctl import thlk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  item_t            item,
  input  entry_t           entry,
  input  logic [KEY_W-1:0] act_key,
  output decision_t        dec
);

  logic [1:0]           level;
  logic [1:0]           level_next;
  logic [KEY_CODES-1:0] held;
  logic                 in_table;
  logic [KEY_IDX_W-1:0] idx;
  logic                 held_set;
  logic                 held_clr;

  assign in_table = ({1'b0, item.key} < (KEY_W + 1)'(KEY_CODES));
  assign idx      = item.key[KEY_IDX_W-1:0];

  always_comb begin
    level_next = level;
    held_set   = 1'b0;
    held_clr   = 1'b0;
    dec        = '0;
    dec.r0.action = ACT_PASS;
    dec.r1.action = ACT_PASS;
    dec.r0.last   = 1'b1;
    dec.r1.last   = 1'b1;
    case (item.func)
      FUNC_DOWN, FUNC_UP: begin
        dec.count = 2'd1;
        if (item.injected) begin
          dec.r0.action = ACT_PASS;
        end else if (item.func == FUNC_DOWN) begin
          if (item.key == act_key) begin
            if (level != LEVEL_MAX) begin
              level_next = level + 2'd1;
            end
            dec.r0.action = ACT_SWALLOW;
          end else if (level != 2'd0) begin
            level_next = LEVEL_MAX;
            if (entry.target != 8'd0) begin
              held_set      = in_table;
              dec.r0.action = ACT_EMIT;
              dec.r0.key    = entry.target;
              dec.r0.flags  = entry.flags;
            end
          end
        end else begin
          if (item.key == act_key) begin
            level_next = 2'd0;
            if (level == LEVEL_TAP) begin
              // Lone tap of the switch key: send a down and an up.
              dec.count     = 2'd2;
              dec.r0.action = ACT_EMIT;
              dec.r0.key    = item.key;
              dec.r0.flags  = entry.flags;
              dec.r0.last   = 1'b0;
              dec.r1.action = ACT_EMIT;
              dec.r1.key    = item.key;
              dec.r1.flags  = entry.flags | FLAG_KEYUP;
            end else begin
              dec.r0.action = ACT_SWALLOW;
            end
          end else if (in_table && held[idx]) begin
            held_clr      = 1'b1;
            dec.r0.action = ACT_EMIT;
            dec.r0.key    = entry.target;
            dec.r0.flags  = entry.flags | FLAG_KEYUP;
          end
        end
      end
      default: begin
        dec.count = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 2'd0;
      held  <= '0;
    end else if (go) begin
      level <= level_next;
      if (held_set) begin
        held[idx] <= 1'b1;
      end else if (held_clr) begin
        held[idx] <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/thlk_out_queue.sv
module thlk_out_queue import thlk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  decision_t dec,
  input  logic      m_tready,
  output logic      m_tvalid,
  output result_t   res,
  output logic      can_take
);

  logic    ov;
  logic    pv;
  result_t pend;
  logic    out_free;

  assign out_free = !ov || m_tready;
  assign can_take = out_free && !pv;
  assign m_tvalid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      pv <= 1'b0;
    end else if (out_free) begin
      if (pv) begin
        res <= pend;
        ov  <= 1'b1;
        pv  <= 1'b0;
      end else if (load && dec.count != 2'd0) begin
        res <= dec.r0;
        ov  <= 1'b1;
        if (dec.count == 2'd2) begin
          pend <= dec.r1;
          pv   <= 1'b1;
        end
      end else begin
        ov <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/tap_hold_layer_key_remapper.sv
// Channel   Direction  Word contents (lowest bit first)
// s_*       in         tdata: key_code, map_target, map_flags; tuser: func, own_injected
// m_*       out        tdata: out_key, out_flags; tuser: action; tlast: last
// cfg_*     in         write of activation_key, no read-back
//
// A word is accepted every cycle while results drain freely; a lone tap of the
// activation key yields two result words, so the word after it, if it yields a
// result, waits for the second to enter the output register. The map entry is read
// at the accepting edge, and the result word is registered as the execute stage retires.
// Reset (synchronous, active high) clears the level, held bits and map valid bits
// at once; a stalled output stops an execute stage with results, which drops s_tready.
module tap_hold_layer_key_remapper import thlk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // key_code, map_target, map_flags
  input  logic [2:0]  s_tuser,   // func, own_injected
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_key, out_flags
  output logic [1:0]  m_tuser,   // action
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic             accept;
  item_t            in_item;
  item_t            s1;
  logic             s1v;
  logic             go;
  logic             can_take;
  logic             in_inside;
  logic             map_we;
  entry_t           entry;
  decision_t        dec;
  result_t          res;
  logic [KEY_W-1:0] act_key;

  // Unpack the incoming word into its fields.
  assign in_item.func     = func_t'(s_tuser[1:0]);
  assign in_item.injected = s_tuser[2];
  assign in_item.key      = s_tdata[7:0];
  assign in_item.target   = s_tdata[15:8];
  assign in_item.flags    = s_tdata[23:16];

  assign accept    = s_tvalid && s_tready;
  assign in_inside = ({1'b0, in_item.key} < (KEY_W + 1)'(KEY_CODES));

  // Map writes take effect as the word is accepted, so any later word reads
  // the new entry; a word already in the execute stage read its entry earlier.
  assign map_we = accept && (in_item.func == FUNC_WRITE) && in_inside;

  // The execute stage retires when it yields no result or the output side
  // has room for everything it yields.
  assign go       = s1v && ((dec.count == 2'd0) || can_take);
  assign s_tready = !s1v || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v     <= 1'b0;
      act_key <= ACT_KEY_RESET;
    end else begin
      if (accept) begin
        s1v <= 1'b1;
      end else if (go) begin
        s1v <= 1'b0;
      end
      if (cfg_we) begin
        act_key <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_item;
    end
  end

  thlk_map_mem u_map (
    .clk   (clk),
    .rst   (rst),
    .we    (map_we),
    .waddr (in_item.key[KEY_IDX_W-1:0]),
    .wdata ({in_item.flags, in_item.target}),
    .re    (accept),
    .raddr (in_item.key[KEY_IDX_W-1:0]),
    .rdata (entry)
  );

  thlk_layer_ctl u_ctl (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .item    (s1),
    .entry   (entry),
    .act_key (act_key),
    .dec     (dec)
  );

  thlk_out_queue u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (go),
    .dec      (dec),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .res      (res),
    .can_take (can_take)
  );

  assign m_tdata = {res.flags, res.key};
  assign m_tuser = res.action;
  assign m_tlast = res.last;

endmodule
